// ===== rtl/core/lsra_pkg.sv =====
// Shared constants, entry and command types for the linear-scan register allocator.
// Used by the channel interfaces, the cell row, the controller, the top level and the checker.
package lsra_pkg;

  localparam int NUM_REGS     = 7;
  localparam int FIRST_REG    = 4;
  localparam int LAST_REG     = FIRST_REG + NUM_REGS - 1;
  localparam int POS_BITS     = 16;
  localparam int END_BITS     = POS_BITS + 1;
  localparam int TAG_BITS     = 16;
  localparam int OUT_REG_BITS = 4;
  localparam int REG_IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_BITS     = $clog2(NUM_REGS + 1);

  // One active interval; end_pos holds a two's complement value
  typedef struct packed {
    logic [END_BITS-1:0]     end_pos;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic [TAG_BITS-1:0]     tag;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_EVICT  = 2'd2
  } cell_op_e;

  // Broadcast from the top level to every cell
  typedef struct packed {
    cell_op_e            op;
    entry_t              new_entry;
    logic [POS_BITS-1:0] start_pos;
  } cell_cmd_t;

  // What a cell shows its neighbors
  typedef struct packed {
    entry_t entry;
    logic   gt;
  } cell_link_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_PLACE = 1'b1
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic place_en;
  } ctrl_t;

endpackage

// ===== rtl/core/lsra_req_if.sv =====
// Request channel of the allocator: one live interval per transfer.
// Depends on lsra_pkg for field widths.
interface lsra_req_if;
  import lsra_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [TAG_BITS-1:0]        interval_id;
  logic [POS_BITS-1:0]        start_pos;
  logic signed [END_BITS-1:0] end_pos;
  logic                       new_function;

  modport source (output valid, output interval_id, output start_pos, output end_pos,
                  output new_function, input ready);
  modport sink   (input valid, input interval_id, input start_pos, input end_pos,
                  input new_function, output ready);
endinterface

// ===== rtl/core/lsra_rsp_if.sv =====
// Response channel of the allocator: one allocation result per request.
// Depends on lsra_pkg for field widths.
interface lsra_rsp_if;
  import lsra_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TAG_BITS-1:0]     echo_id;
  logic [OUT_REG_BITS-1:0] assigned_reg;
  logic                    self_spilled;
  logic                    evicted_valid;
  logic [TAG_BITS-1:0]     evicted_id;
  logic                    any_spill;

  modport source (output valid, output echo_id, output assigned_reg, output self_spilled,
                  output evicted_valid, output evicted_id, output any_spill, input ready);
  modport sink   (input valid, input echo_id, input assigned_reg, input self_spilled,
                  input evicted_valid, input evicted_id, input any_spill, output ready);
endinterface

// ===== rtl/core/lsra_cell.sv =====
// One slot of the active list, kept sorted by decreasing end from cell 0 upward.
// Depends on lsra_pkg; neighbors exchange entries through cell_link_t.
module lsra_cell (
  input  logic                 clk_i,
  input  lsra_pkg::cell_cmd_t  cmd_i,
  input  logic                 occ_i,
  input  lsra_pkg::cell_link_t left_i,
  input  lsra_pkg::cell_link_t right_i,
  output lsra_pkg::cell_link_t link_o,
  output logic                 expired_o
);
  import lsra_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt;

  assign gt = occ_i &&
              ($signed(entry_q.end_pos) > $signed(cmd_i.new_entry.end_pos));
  assign expired_o = occ_i &&
                     ($signed(entry_q.end_pos) < $signed({1'b0, cmd_i.start_pos}));

  assign link_o.entry = entry_q;
  assign link_o.gt    = gt;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        // later ends stay; the first slot past them takes the new entry, the rest shift up
        if (!gt) begin
          entry_d = left_i.gt ? cmd_i.new_entry : left_i.entry;
        end
      end
      CELL_EVICT: begin
        // cell 0 drops out; later ends shift down toward the gap
        if (right_i.gt) begin
          entry_d = right_i.entry;
        end else if (gt) begin
          entry_d = cmd_i.new_entry;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/core/lsra_ctrl.sv =====
// Two-state sequencer: take a request and expire, then place it into the cell row.
// Depends on lsra_pkg for state_e and ctrl_t.
module lsra_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_busy_i,
  output lsra_pkg::ctrl_t ctrl_o
);
  import lsra_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PLACE;
      ST_PLACE: if (!out_busy_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      ST_IDLE:  ctrl_o.in_ready = 1'b1;
      ST_PLACE: ctrl_o.place_en = !out_busy_i;
      default:  ctrl_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/linear_scan_register_allocator.sv =====
// Linear-scan register allocator for registers FIRST_REG..LAST_REG.
// Requests on req_i carry one live interval each (id, start, end, new-function flag),
// in order of increasing start. A request is taken when valid and ready are both high.
// At the accepting edge the active list expires every entry ending before the new start
// (or empties first on new_function); then the place state puts the interval in the cell row:
// lowest free register, else evict the latest-ending entry if it ends later, else spill.
// Each request yields exactly one response on rsp_o, valid from the edge that closes the
// place cycle. A new request is not taken until the current one is placed in the
// seven-cell active list; ready is low during the place cycle.
// The response sits in an output register; while it is stalled the next request is still
// taken and expired, and its place cycle waits until the held response is taken.
// Reset (rst_ni low, asynchronous) empties the active list, frees every register,
// clears the spill flag and drops any pending response. The cell entries need no reset.
// Depends on lsra_pkg, lsra_req_if, lsra_rsp_if, lsra_cell and lsra_ctrl.
module linear_scan_register_allocator (
  input  logic clk_i,
  input  logic rst_ni,
  lsra_req_if.sink   req_i,
  lsra_rsp_if.source rsp_o
);
  import lsra_pkg::*;

  typedef struct packed {
    logic [TAG_BITS-1:0]     echo_id;
    logic [OUT_REG_BITS-1:0] assigned_reg;
    logic                    self_spilled;
    logic                    evicted_valid;
    logic [TAG_BITS-1:0]     evicted_id;
    logic                    any_spill;
  } result_t;

  localparam cell_link_t HeadLink = '{entry: '0, gt: 1'b1};
  localparam cell_link_t TailLink = '{entry: '0, gt: 1'b0};

  ctrl_t                   ctrl;
  logic                    accept;
  logic                    out_busy;
  logic                    out_valid_q, out_valid_d;
  result_t                 res_q, res_d;

  logic [CNT_BITS-1:0]     count_q, count_d, cnt_eff, occ_cnt, n_exp;
  logic [NUM_REGS-1:0]     free_q, free_d, free_eff, freed;
  logic                    spill_q, spill_d;
  logic [TAG_BITS-1:0]     pend_tag_q;
  logic [END_BITS-1:0]     pend_end_q;

  cell_cmd_t               cmd;
  cell_link_t              links [NUM_REGS];
  logic [NUM_REGS-1:0]     occ;
  logic [NUM_REGS-1:0]     expired;

  logic [REG_IDX_BITS-1:0] low_idx, pick_idx;
  logic                    has_free, do_evict;

  lsra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  assign req_i.ready = ctrl.in_ready;
  assign accept      = req_i.valid && ctrl.in_ready;
  assign out_busy    = out_valid_q && !rsp_o.ready;

  // Occupancy follows the post-flush count during expire, the stored count during place
  assign cnt_eff = req_i.new_function ? '0 : count_q;
  assign occ_cnt = ctrl.in_ready ? cnt_eff : count_q;

  for (genvar i = 0; i < NUM_REGS; i++) begin : g_cell
    cell_link_t left_lnk, right_lnk;

    if (i == 0) begin : g_head
      assign left_lnk = HeadLink;
    end else begin : g_left
      assign left_lnk = links[i-1];
    end

    if (i == NUM_REGS - 1) begin : g_tail
      assign right_lnk = TailLink;
    end else begin : g_right
      assign right_lnk = links[i+1];
    end

    assign occ[i] = (CNT_BITS'(i) < occ_cnt);

    lsra_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .occ_i     (occ[i]),
      .left_i    (left_lnk),
      .right_i   (right_lnk),
      .link_o    (links[i]),
      .expired_o (expired[i])
    );
  end

  // Expired entries form the tail of the occupied cells; count them and free their regs
  always_comb begin
    n_exp = '0;
    freed = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      n_exp = n_exp + CNT_BITS'(expired[i]);
      if (expired[i]) begin
        freed = freed | (NUM_REGS'(1) << links[i].entry.reg_idx);
      end
    end
  end

  assign free_eff = req_i.new_function ? {NUM_REGS{1'b1}} : free_q;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_REGS - 1; i >= 0; i--) begin
      if (free_q[i]) low_idx = REG_IDX_BITS'(i);
    end
  end

  assign has_free = |free_q;
  assign do_evict = !has_free && links[0].gt;
  assign pick_idx = has_free ? low_idx : links[0].entry.reg_idx;

  always_comb begin
    cmd.new_entry.end_pos = pend_end_q;
    cmd.new_entry.reg_idx = pick_idx;
    cmd.new_entry.tag     = pend_tag_q;
    cmd.start_pos         = req_i.start_pos;
    cmd.op                = CELL_HOLD;
    if (ctrl.place_en) begin
      if (has_free) begin
        cmd.op = CELL_INSERT;
      end else if (do_evict) begin
        cmd.op = CELL_EVICT;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    free_d  = free_q;
    spill_d = spill_q;
    res_d   = res_q;
    if (accept) begin
      count_d = cnt_eff - n_exp;
      free_d  = free_eff | freed;
      spill_d = spill_q && !req_i.new_function;
    end else if (ctrl.place_en) begin
      res_d.echo_id       = pend_tag_q;
      res_d.assigned_reg  = OUT_REG_BITS'(FIRST_REG) + OUT_REG_BITS'(pick_idx);
      res_d.self_spilled  = 1'b0;
      res_d.evicted_valid = 1'b0;
      res_d.evicted_id    = '0;
      if (has_free) begin
        count_d = count_q + CNT_BITS'(1);
        free_d  = free_q & ~(NUM_REGS'(1) << low_idx);
      end else if (do_evict) begin
        res_d.evicted_valid = 1'b1;
        res_d.evicted_id    = links[0].entry.tag;
        spill_d             = 1'b1;
      end else begin
        res_d.assigned_reg = '0;
        res_d.self_spilled = 1'b1;
        spill_d            = 1'b1;
      end
      res_d.any_spill = spill_d;
    end
  end

  assign out_valid_d = ctrl.place_en || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      free_q      <= {NUM_REGS{1'b1}};
      spill_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      free_q      <= free_d;
      spill_q     <= spill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the request payload for the place cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_tag_q <= req_i.interval_id;
      pend_end_q <= req_i.end_pos;
    end
    res_q <= res_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.echo_id       = res_q.echo_id;
  assign rsp_o.assigned_reg  = res_q.assigned_reg;
  assign rsp_o.self_spilled  = res_q.self_spilled;
  assign rsp_o.evicted_valid = res_q.evicted_valid;
  assign rsp_o.evicted_id    = res_q.evicted_id;
  assign rsp_o.any_spill     = res_q.any_spill;

endmodule

// ===== rtl/core/lsra_checker.sv =====
// Port-level checks for the allocator, attached to the top level by bind.
// Depends on lsra_pkg for the register range.
module lsra_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [lsra_pkg::TAG_BITS-1:0]     rsp_echo_id_i,
  input logic [lsra_pkg::OUT_REG_BITS-1:0] rsp_assigned_reg_i,
  input logic                              rsp_self_spilled_i,
  input logic                              rsp_evicted_valid_i,
  input logic                              rsp_any_spill_i
);
  import lsra_pkg::*;

  // a taken request goes on to its place cycle, so no request can follow it at once
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken in the cycle after an accept");

  // a fresh response only comes out of a place cycle
  a_rsp_after_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("response appeared without a place cycle");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_echo_id_i) && $stable(rsp_assigned_reg_i)))
    else $error("stalled response changed");

  // a spill of either kind raises the sticky flag; a granted register lies in range
  a_rsp_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      ((rsp_self_spilled_i && !rsp_evicted_valid_i && rsp_any_spill_i &&
        (rsp_assigned_reg_i == '0)) ||
       (!rsp_self_spilled_i && (!rsp_evicted_valid_i || rsp_any_spill_i) &&
        (rsp_assigned_reg_i >= OUT_REG_BITS'(FIRST_REG)) &&
        (rsp_assigned_reg_i <= OUT_REG_BITS'(LAST_REG)))))
    else $error("inconsistent response fields");

endmodule

bind linear_scan_register_allocator lsra_checker u_lsra_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_echo_id_i       (rsp_o.echo_id),
  .rsp_assigned_reg_i  (rsp_o.assigned_reg),
  .rsp_self_spilled_i  (rsp_o.self_spilled),
  .rsp_evicted_valid_i (rsp_o.evicted_valid),
  .rsp_any_spill_i     (rsp_o.any_spill)
);
